// ===== sv/slcd_pkg.sv =====
// Package for the sync/length/sum-8 deframer: shared types, register indexes,
// phase and reply-position codes, and frame limits. No dependencies.
package slcd_pkg;

	// Largest body the deframer accepts; a length byte is body + 1
	localparam int PAYLOAD_MAX = 128;

	localparam int BYTE_W    = 8;
	localparam int SYNC_W    = 16;
	localparam int IDX_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [BYTE_W-1:0] LEN_MIN        = 8'd2;
	localparam logic [BYTE_W-1:0] LEN_MAX        = 8'(PAYLOAD_MAX + 1);
	localparam logic [BYTE_W-1:0] REPLY_LEN_BYTE = 8'(1 + 2);

	// Register reset values
	localparam logic [SYNC_W-1:0] SYNC_WORD_RST   = 16'hAA55;
	localparam logic [BYTE_W-1:0] ACK_ADDRESS_RST = 8'h00;
	localparam logic [BYTE_W-1:0] ACK_CODE_RST    = 8'h00;
	localparam logic [BYTE_W-1:0] NACK_CODE_RST   = 8'h01;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_WORD   = 2'd0,
		REG_ACK_ADDRESS = 2'd1,
		REG_ACK_CODE    = 2'd2,
		REG_NACK_CODE   = 2'd3
	} cfg_reg_t;

	// Receive phase
	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2,
		PH_SUM  = 2'd3
	} phase_t;

	// Result kind
	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_REPLY   = 1'b1
	} kind_t;

	// Byte position within the reply frame
	typedef enum logic [2:0] {
		RP_SYNC_HI = 3'd0,
		RP_SYNC_LO = 3'd1,
		RP_LEN     = 3'd2,
		RP_ADDR    = 3'd3,
		RP_CODE    = 3'd4,
		RP_CSUM    = 3'd5
	} reply_pos_t;

	typedef struct packed {
		logic [SYNC_W-1:0] sync_word;
		logic [BYTE_W-1:0] ack_address;
		logic [BYTE_W-1:0] ack_code;
		logic [BYTE_W-1:0] nack_code;
	} cfg_t;

	// One output job: a payload byte, or a whole reply frame
	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] data;       // payload byte, or reply code
		logic [IDX_W-1:0]  index;      // zero on replies
		logic              good;       // zero on payload
		logic [SYNC_W-1:0] sync_word;
		logic [BYTE_W-1:0] address;
		logic [BYTE_W-1:0] csum;
	} job_t;

endpackage

// ===== sv/slcd_rx_if.sv =====
// Receive byte channel: valid/ready handshake with one byte of payload.
// Depends on slcd_pkg.
interface slcd_rx_if;
	logic                        valid;
	logic                        ready;
	logic [slcd_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/slcd_res_if.sv =====
// Result channel: payload bytes and reply frame bytes with valid/ready.
// Depends on slcd_pkg.
interface slcd_res_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [slcd_pkg::BYTE_W-1:0] data_byte;
	logic [slcd_pkg::IDX_W-1:0]  payload_index;
	logic                        checksum_good;
	logic                        last;

	modport source (output valid, output kind, output data_byte, output payload_index,
		output checksum_good, output last, input ready);
	modport sink (input valid, input kind, input data_byte, input payload_index,
		input checksum_good, input last, output ready);
endinterface

// ===== sv/slcd_cfg_if.sv =====
// Configuration write channel: register index and write data with valid/ready.
// Depends on slcd_pkg.
interface slcd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [slcd_pkg::CFG_IDX_W-1:0] index;
	logic [slcd_pkg::CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/slcd_cfg_regs.sv =====
// Configuration register file of the deframer; always ready for a write.
// Depends on slcd_pkg.
module slcd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_valid,
	output logic                           wr_ready,
	input  logic [slcd_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [slcd_pkg::CFG_DAT_W-1:0] wr_data,
	output slcd_pkg::cfg_t                 cfg
);

	slcd_pkg::cfg_t cfg_q;

	assign wr_ready = 1'b1;
	assign cfg      = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_word   <= slcd_pkg::SYNC_WORD_RST;
			cfg_q.ack_address <= slcd_pkg::ACK_ADDRESS_RST;
			cfg_q.ack_code    <= slcd_pkg::ACK_CODE_RST;
			cfg_q.nack_code   <= slcd_pkg::NACK_CODE_RST;
		end else if (wr_valid) begin
			unique case (slcd_pkg::cfg_reg_t'(wr_index))
				slcd_pkg::REG_SYNC_WORD:   cfg_q.sync_word   <= wr_data;
				slcd_pkg::REG_ACK_ADDRESS: cfg_q.ack_address <= wr_data[slcd_pkg::BYTE_W-1:0];
				slcd_pkg::REG_ACK_CODE:    cfg_q.ack_code    <= wr_data[slcd_pkg::BYTE_W-1:0];
				slcd_pkg::REG_NACK_CODE:   cfg_q.nack_code   <= wr_data[slcd_pkg::BYTE_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/slcd_parser.sv =====
// Frame parser: sync hunt, length check, body count and running sum. Each
// accepted byte updates the parse state and may post one job to a register.
// Depends on slcd_pkg.
module slcd_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rx_valid,
	output logic                        rx_ready,
	input  logic [slcd_pkg::BYTE_W-1:0] rx_byte,
	input  slcd_pkg::cfg_t              cfg,
	output slcd_pkg::job_t              job,
	output logic                        job_valid,
	input  logic                        job_take
);

	logic [slcd_pkg::SYNC_W-1:0] sync_window_q, sync_window_d;
	slcd_pkg::phase_t            phase_q, phase_d;
	logic [slcd_pkg::BYTE_W-1:0] frame_length_q, frame_length_d;
	logic [slcd_pkg::BYTE_W-1:0] body_count_q, body_count_d;
	logic [slcd_pkg::BYTE_W-1:0] running_sum_q, running_sum_d;
	logic [slcd_pkg::SYNC_W-1:0] window_shift;
	logic [slcd_pkg::BYTE_W-1:0] code;
	logic                        good;
	slcd_pkg::job_t              job_d, job_s1;
	logic                        job_gen;
	logic                        job_v_s1;
	logic                        accept;

	// Job register frees when the output stage takes it
	assign rx_ready  = !job_v_s1 || job_take;
	assign accept    = rx_valid && rx_ready;
	assign job       = job_s1;
	assign job_valid = job_v_s1;

	assign window_shift = {sync_window_q[slcd_pkg::BYTE_W-1:0], rx_byte};
	assign good         = (running_sum_q == rx_byte);
	assign code         = good ? cfg.ack_code : cfg.nack_code;

	// Next parse state and job for the incoming byte
	always_comb begin
		sync_window_d  = sync_window_q;
		phase_d        = phase_q;
		frame_length_d = frame_length_q;
		body_count_d   = body_count_q;
		running_sum_d  = running_sum_q;
		job_d          = '0;
		job_gen        = 1'b0;
		unique case (phase_q)
			slcd_pkg::PH_HUNT: begin
				if (window_shift == cfg.sync_word) begin
					phase_d        = slcd_pkg::PH_LEN;
					frame_length_d = '0;
					body_count_d   = '0;
					running_sum_d  = '0;
					sync_window_d  = '0;
				end else begin
					sync_window_d = window_shift;
				end
			end
			slcd_pkg::PH_LEN: begin
				if (rx_byte < slcd_pkg::LEN_MIN || rx_byte > slcd_pkg::LEN_MAX) begin
					phase_d       = slcd_pkg::PH_HUNT;
					sync_window_d = '0;
				end else begin
					frame_length_d = rx_byte;
					running_sum_d  = running_sum_q + rx_byte;
					phase_d        = slcd_pkg::PH_BODY;
				end
			end
			slcd_pkg::PH_BODY: begin
				job_gen       = 1'b1;
				job_d.kind    = slcd_pkg::KIND_PAYLOAD;
				job_d.data    = rx_byte;
				job_d.index   = body_count_q[slcd_pkg::IDX_W-1:0];
				running_sum_d = running_sum_q + rx_byte;
				body_count_d  = body_count_q + 8'd1;
				if (body_count_d == frame_length_q - 8'd1) begin
					phase_d = slcd_pkg::PH_SUM;
				end
			end
			slcd_pkg::PH_SUM: begin
				job_gen         = 1'b1;
				job_d.kind      = slcd_pkg::KIND_REPLY;
				job_d.data      = code;
				job_d.good      = good;
				job_d.sync_word = cfg.sync_word;
				job_d.address   = cfg.ack_address;
				job_d.csum      = slcd_pkg::REPLY_LEN_BYTE + cfg.ack_address + code;
				phase_d         = slcd_pkg::PH_HUNT;
				sync_window_d   = '0;
			end
			default: ;
		endcase
	end

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_window_q  <= '0;
			phase_q        <= slcd_pkg::PH_HUNT;
			frame_length_q <= '0;
			body_count_q   <= '0;
			running_sum_q  <= '0;
		end else if (accept) begin
			sync_window_q  <= sync_window_d;
			phase_q        <= phase_d;
			frame_length_q <= frame_length_d;
			body_count_q   <= body_count_d;
			running_sum_q  <= running_sum_d;
		end
	end

	// Job register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_s1 <= 1'b0;
		end else if (accept) begin
			job_v_s1 <= job_gen;
		end else if (job_take) begin
			job_v_s1 <= 1'b0;
		end
	end

	// Job payload
	always_ff @(posedge clk) begin
		if (accept && job_gen) begin
			job_s1 <= job_d;
		end
	end

endmodule

// ===== sv/slcd_out_stage.sv =====
// Output stage: holds one job and plays it out, one result per transaction;
// a reply job becomes six bytes. Depends on slcd_pkg.
module slcd_out_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  slcd_pkg::job_t              job,
	input  logic                        job_valid,
	output logic                        job_take,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic                        res_kind,
	output logic [slcd_pkg::BYTE_W-1:0] res_data_byte,
	output logic [slcd_pkg::IDX_W-1:0]  res_payload_index,
	output logic                        res_checksum_good,
	output logic                        res_last
);

	slcd_pkg::job_t       cur_q;
	slcd_pkg::reply_pos_t pos_q;
	logic                 busy_q;
	logic                 final_byte;
	logic                 res_done;
	logic                 free;

	// Payload jobs end after one byte, replies after the checksum byte
	assign final_byte = (cur_q.kind == slcd_pkg::KIND_PAYLOAD) || (pos_q == slcd_pkg::RP_CSUM);
	assign res_done   = busy_q && res_ready;
	assign free       = !busy_q || (res_done && final_byte);
	assign job_take   = job_valid && free;

	// Current job and reply position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= slcd_pkg::RP_SYNC_HI;
		end else if (job_take) begin
			busy_q <= 1'b1;
			pos_q  <= slcd_pkg::RP_SYNC_HI;
		end else if (res_done) begin
			if (final_byte) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= slcd_pkg::reply_pos_t'(pos_q + 3'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			cur_q <= job;
		end
	end

	// Result fields
	assign res_valid         = busy_q;
	assign res_kind          = cur_q.kind;
	assign res_payload_index = cur_q.index;
	assign res_checksum_good = cur_q.good;
	assign res_last          = (cur_q.kind == slcd_pkg::KIND_REPLY) &&
		(pos_q == slcd_pkg::RP_CSUM);

	always_comb begin
		if (cur_q.kind == slcd_pkg::KIND_PAYLOAD) begin
			res_data_byte = cur_q.data;
		end else begin
			unique case (pos_q)
				slcd_pkg::RP_SYNC_HI: res_data_byte = cur_q.sync_word[15:8];
				slcd_pkg::RP_SYNC_LO: res_data_byte = cur_q.sync_word[7:0];
				slcd_pkg::RP_LEN:     res_data_byte = slcd_pkg::REPLY_LEN_BYTE;
				slcd_pkg::RP_ADDR:    res_data_byte = cur_q.address;
				slcd_pkg::RP_CODE:    res_data_byte = cur_q.data;
				slcd_pkg::RP_CSUM:    res_data_byte = cur_q.csum;
				default:              res_data_byte = '0;
			endcase
		end
	end

endmodule

// ===== sv/sync_length_checksum_deframer_unit.sv =====
// Deframer top level. A payload byte goes from rx through the parser job register
// and the output stage's current job to res; a checksum byte's six-byte reply likewise.
// rx takes a byte every cycle while the job register frees; a reply holds the
// output stage for six res transactions, one per cycle when res is ready.
// arst_n clears the parse state to hunting and loads register defaults.
// Depends on slcd_pkg, the three channel interfaces and the submodules.
module sync_length_checksum_deframer_unit (
	input  logic        clk,
	input  logic        arst_n,
	slcd_rx_if.sink     rx,
	slcd_res_if.source  res,
	slcd_cfg_if.sink    cfg
);

	slcd_pkg::cfg_t cfg_vals;
	slcd_pkg::job_t job;
	logic           job_valid;
	logic           job_take;

	slcd_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_ready (cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_vals)
	);

	slcd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx.valid),
		.rx_ready  (rx.ready),
		.rx_byte   (rx.rx_byte),
		.cfg       (cfg_vals),
		.job       (job),
		.job_valid (job_valid),
		.job_take  (job_take)
	);

	slcd_out_stage u_out_stage (
		.clk               (clk),
		.arst_n            (arst_n),
		.job               (job),
		.job_valid         (job_valid),
		.job_take          (job_take),
		.res_valid         (res.valid),
		.res_ready         (res.ready),
		.res_kind          (res.kind),
		.res_data_byte     (res.data_byte),
		.res_payload_index (res.payload_index),
		.res_checksum_good (res.checksum_good),
		.res_last          (res.last)
	);

endmodule

// ===== tb/tb_top.sv =====
// Testbench for sync_length_checksum_deframer_unit: feeds received bytes and register writes,
// predicts payload and reply bytes, and checks each result transaction in order.
// Depends on slcd_pkg, the slcd_rx_if/slcd_res_if/slcd_cfg_if interfaces and the deframer RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import slcd_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam int MAX_REPORTS  = 10;
	localparam int RANDOM_ITEMS = 300;

	// One result byte as the predictor sees it
	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] data;
		logic [IDX_W-1:0]  idx;
		logic              good;
		logic              last;
	} out_byte_t;

	logic clk;
	logic arst_n;

	slcd_rx_if  rx_ch ();
	slcd_res_if res_ch ();
	slcd_cfg_if cfg_ch ();

	sync_length_checksum_deframer_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// Register copies, at their reset values
	logic [SYNC_W-1:0] sync_r = SYNC_WORD_RST;
	logic [BYTE_W-1:0] addr_r = ACK_ADDRESS_RST;
	logic [BYTE_W-1:0] ack_r  = ACK_CODE_RST;
	logic [BYTE_W-1:0] nack_r = NACK_CODE_RST;

	// Parser state copy
	logic [SYNC_W-1:0] hunt_win  = '0;
	phase_t            parse_ph  = PH_HUNT;
	logic [BYTE_W-1:0] frame_len = '0;
	logic [BYTE_W-1:0] body_n    = '0;
	logic [BYTE_W-1:0] sum8      = '0;

	logic [BYTE_W-1:0] rx_bytes_q[$];
	out_byte_t         deframed_q[$];
	out_byte_t         seen;
	out_byte_t         want;

	int mismatches  = 0;
	int cycles      = 0;
	int bytes_in    = 0;
	int n_payload   = 0;
	int n_ack       = 0;
	int n_nack      = 0;
	int n_bad_len   = 0;
	int n_cfg       = 0;
	int frame_items = 0;
	int burst_left  = 1;
	int gap_left    = 0;
	logic       rx_took = 1'b0;
	logic [7:0] rdy_step = '0;

	// Clock, 12 ns period
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic string fmt_out(out_byte_t o);
		return $sformatf("kind %0d data %02h idx %0d good %0d last %0d",
			o.kind, o.data, o.idx, o.good, o.last);
	endfunction

	function automatic void log_mismatch(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("ERROR @%0t ns: %s", $time, msg);
	endfunction

	function automatic void expect_out(kind_t k, logic [BYTE_W-1:0] d, logic [IDX_W-1:0] i,
		logic g, logic l);
		out_byte_t o;
		o.kind = k;
		o.data = d;
		o.idx  = i;
		o.good = g;
		o.last = l;
		deframed_q.push_back(o);
	endfunction

	// Register write as the block applies it; 8-bit registers keep the low byte
	function automatic void set_reg(cfg_reg_t r, logic [CFG_DAT_W-1:0] v);
		n_cfg++;
		case (r)
			REG_SYNC_WORD:   sync_r = v;
			REG_ACK_ADDRESS: addr_r = v[BYTE_W-1:0];
			REG_ACK_CODE:    ack_r  = v[BYTE_W-1:0];
			REG_NACK_CODE:   nack_r = v[BYTE_W-1:0];
			default: ;
		endcase
	endfunction

	// Advance the parser by one received byte and queue the bytes it emits
	function automatic void deframe_byte(logic [BYTE_W-1:0] b);
		logic              good;
		logic [BYTE_W-1:0] code;
		bytes_in++;
		case (parse_ph)
			PH_HUNT: begin
				hunt_win = {hunt_win[BYTE_W-1:0], b};
				if (hunt_win == sync_r) begin
					parse_ph  = PH_LEN;
					frame_len = '0;
					body_n    = '0;
					sum8      = '0;
					hunt_win  = '0;
				end
			end
			PH_LEN: begin
				// bad length drops straight back to hunting
				if (b < LEN_MIN || b > LEN_MAX) begin
					parse_ph = PH_HUNT;
					hunt_win = '0;
					n_bad_len++;
				end else begin
					frame_len = b;
					sum8      = sum8 + b;
					parse_ph  = PH_BODY;
				end
			end
			PH_BODY: begin
				expect_out(KIND_PAYLOAD, b, body_n[IDX_W-1:0], 1'b0, 1'b0);
				sum8   = sum8 + b;
				body_n = body_n + 8'd1;
				n_payload++;
				if (body_n == frame_len - 8'd1)
					parse_ph = PH_SUM;
			end
			default: begin
				// reply uses the registers as they stand now
				good = (sum8 == b);
				code = good ? ack_r : nack_r;
				expect_out(KIND_REPLY, sync_r[SYNC_W-1:BYTE_W], '0, good, 1'b0);
				expect_out(KIND_REPLY, sync_r[BYTE_W-1:0], '0, good, 1'b0);
				expect_out(KIND_REPLY, REPLY_LEN_BYTE, '0, good, 1'b0);
				expect_out(KIND_REPLY, addr_r, '0, good, 1'b0);
				expect_out(KIND_REPLY, code, '0, good, 1'b0);
				expect_out(KIND_REPLY, REPLY_LEN_BYTE + addr_r + code, '0, good, 1'b1);
				if (good)
					n_ack++;
				else
					n_nack++;
				parse_ph = PH_HUNT;
				hunt_win = '0;
			end
		endcase
	endfunction

	// Monitor: register writes, accepted bytes, result check, run limit
	always @(posedge clk) begin
		rx_took = 1'b0;
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Run limit of %0d cycles reached", CYCLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end else if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				set_reg(cfg_reg_t'(cfg_ch.index), cfg_ch.data);
			if (rx_ch.valid && rx_ch.ready) begin
				rx_took = 1'b1;
				deframe_byte(rx_ch.rx_byte);
			end
			if (res_ch.valid && res_ch.ready) begin
				seen.kind = kind_t'(res_ch.kind);
				seen.data = res_ch.data_byte;
				seen.idx  = res_ch.payload_index;
				seen.good = res_ch.checksum_good;
				seen.last = res_ch.last;
				if (deframed_q.size() == 0) begin
					log_mismatch({"unexpected result: ", fmt_out(seen)});
				end else begin
					want = deframed_q.pop_front();
					if (seen !== want)
						log_mismatch({"expected ", fmt_out(want), " got ", fmt_out(seen)});
				end
			end
		end
	end

	// Driver: rx bytes in bursts with gaps, res ready on a rotating stall pattern
	always @(negedge clk) begin
		if (!rx_ch.valid || rx_took) begin
			if (gap_left > 0) begin
				gap_left--;
				rx_ch.valid <= 1'b0;
			end else if (rx_bytes_q.size() > 0) begin
				rx_ch.valid   <= 1'b1;
				rx_ch.rx_byte <= rx_bytes_q.pop_front();
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
				end
			end else begin
				rx_ch.valid <= 1'b0;
			end
		end
		rdy_step <= rdy_step + 8'd1;
		case (rdy_step[7:6])
			2'd0:    res_ch.ready <= 1'b1;
			2'd1:    res_ch.ready <= ($urandom_range(0, 3) != 0);
			2'd2:    res_ch.ready <= ((rdy_step % 3) == 0);
			default: res_ch.ready <= ($urandom_range(0, 1) == 1);
		endcase
	end

	task automatic push_byte(input logic [BYTE_W-1:0] b, input bit counted);
		rx_bytes_q.push_back(b);
		if (counted)
			frame_items++;
	endtask

	task automatic push_sync();
		push_byte(sync_r[SYNC_W-1:BYTE_W], 1'b1);
		push_byte(sync_r[BYTE_W-1:0], 1'b1);
	endtask

	// Whole frame with random body; a bad checksum is off by a nonzero amount
	task automatic push_frame(input int len, input bit good);
		logic [BYTE_W-1:0] s;
		logic [BYTE_W-1:0] b;
		push_sync();
		push_byte(8'(len), 1'b1);
		s = 8'(len);
		repeat (len - 1) begin
			b = 8'($urandom_range(0, 255));
			push_byte(b, 1'b1);
			s = s + b;
		end
		push_byte(good ? s : s + 8'($urandom_range(1, 255)), 1'b1);
	endtask

	// Mostly well-formed frames, the rest noise, bad lengths and cut-off frames
	task automatic gen_traffic(input int n);
		int stop;
		int pick;
		int len;
		stop = frame_items + n;
		while (frame_items < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				if ($urandom_range(0, 39) == 0)
					len = $urandom_range(13, LEN_MAX);
				else
					len = $urandom_range(LEN_MIN, 12);
				push_frame(len, $urandom_range(0, 3) != 0);
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 4))
					push_byte(8'($urandom_range(0, 255)), 1'b0);
			end else if (pick < 87) begin
				push_sync();
				if ($urandom_range(0, 1) == 1)
					push_byte(8'($urandom_range(0, LEN_MIN - 1)), 1'b1);
				else
					push_byte(8'($urandom_range(LEN_MAX + 1, 255)), 1'b1);
			end else begin
				// cut-off frame: whatever follows is taken as its body
				len = $urandom_range(4, 12);
				push_sync();
				push_byte(8'(len), 1'b1);
				repeat ($urandom_range(1, len - 3))
					push_byte(8'($urandom_range(0, 255)), 1'b1);
			end
		end
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_DAT_W-1:0] v);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= r;
		cfg_ch.data  <= v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic write_all(input logic [CFG_DAT_W-1:0] s, input logic [CFG_DAT_W-1:0] a,
		input logic [CFG_DAT_W-1:0] ak, input logic [CFG_DAT_W-1:0] nk);
		write_reg(REG_SYNC_WORD, s);
		write_reg(REG_ACK_ADDRESS, a);
		write_reg(REG_ACK_CODE, ak);
		write_reg(REG_NACK_CODE, nk);
	endtask

	// Wait for all bytes taken and all results seen, then let the pipeline empty
	task automatic settle();
		while (rx_bytes_q.size() > 0 || rx_ch.valid || deframed_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// Stimulus sequence
	initial begin
		logic [BYTE_W-1:0] mf_sum;
		logic [BYTE_W-1:0] b;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready  = 1'b0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = REG_SYNC_WORD;
		cfg_ch.data   = '0;
		arst_n        = 1'b0;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset registers: byte extremes, overlapping sync, both bad lengths,
		// a one-byte body of all ones, a checksum miss, a zero length
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(sync_r[SYNC_W-1:BYTE_W], 1'b0);
		push_sync();
		push_byte(LEN_MIN - 8'd1, 1'b1);
		push_sync();
		push_byte(LEN_MAX + 8'd1, 1'b1);
		push_sync();
		push_byte(LEN_MIN, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_byte(LEN_MIN + 8'hFF, 1'b1);
		push_frame(3, 1'b0);
		push_sync();
		push_byte(8'h00, 1'b1);
		push_frame(LEN_MIN, 1'b1);
		settle();
		frame_items = 0;

		// All-ones registers but nack (its low byte is zero), upper data bits set; one frame of the largest length
		write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFF00);
		push_frame(LEN_MAX, 1'b1);
		push_byte(8'hFF, 1'b0);
		gen_traffic(40);
		settle();

		// All-zero registers, except nack at all ones
		write_all(16'h0000, 16'hFF00, 16'h5A00, 16'h00FF);
		gen_traffic(30);
		settle();

		// Registers change while a frame waits for its checksum
		write_reg(REG_SYNC_WORD, 16'($urandom_range(0, 65535)));
		push_sync();
		push_byte(8'd5, 1'b1);
		mf_sum = 8'd5;
		repeat (4) begin
			b = 8'($urandom_range(0, 255));
			push_byte(b, 1'b1);
			mf_sum = mf_sum + b;
		end
		settle();
		write_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
		push_byte(mf_sum, 1'b1);
		gen_traffic(30);
		settle();

		// Random register settings
		while (frame_items < RANDOM_ITEMS) begin
			write_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
			gen_traffic($urandom_range(25, 50));
			settle();
		end

		repeat (DRAIN_CYCLES)
			@(posedge clk);
		$display("Covered %0d received bytes and %0d register writes: %0d payload bytes,",
			bytes_in, n_cfg, n_payload);
		$display("%0d reply frames (%0d checksum good, %0d bad), %0d lengths rejected.",
			n_ack + n_nack, n_ack, n_nack, n_bad_len);
		if (deframed_q.size() != 0)
			$display("%0d expected results never arrived", deframed_q.size());
		if (mismatches == 0 && deframed_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
